/* sv/four_pole_resonant_lowpass_unit_macros.svh */
// Assertion helpers shared by the filter RTL.
`ifndef FOUR_POLE_RESONANT_LOWPASS_UNIT_MACROS_SVH
`define FOUR_POLE_RESONANT_LOWPASS_UNIT_MACROS_SVH

// Antecedent and consequent in the same cycle.
`define FPRL_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent in the cycle after the antecedent.
`define FPRL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/fprl_pkg.sv */
package fprl_pkg;

  localparam int SAMPLE_W  = 24;
  localparam int COEF_W    = 32;
  localparam int DELAY_W   = 48;
  localparam int COEF_FRAC = COEF_W - 4;
  localparam int PROD_W    = SAMPLE_W + COEF_W;
  localparam int T1_W      = PROD_W - COEF_FRAC;
  localparam int T4_W      = T1_W + 2;
  localparam int T6_W      = T1_W + 3;
  localparam int YSUM_W    = DELAY_W + 1;
  localparam int ACC_W     = DELAY_W + 2;
  localparam int NUM_DELAY = 4;
  localparam int REG_IDX_W = 3;
  localparam int STEP_W    = 3;

  typedef logic [REG_IDX_W-1:0] reg_idx_t;
  localparam reg_idx_t REG_GAIN = 3'd0;
  localparam reg_idx_t REG_FB1  = 3'd1;
  localparam reg_idx_t REG_FB2  = 3'd2;
  localparam reg_idx_t REG_FB3  = 3'd3;
  localparam reg_idx_t REG_FB4  = 3'd4;

  typedef logic [STEP_W-1:0] step_t;
  localparam step_t STEP_IDLE  = 3'd0;
  localparam step_t STEP_MUL_X = 3'd1;
  localparam step_t STEP_Y     = 3'd2;
  localparam step_t STEP_MUL_F = 3'd3;
  localparam step_t STEP_ACC0  = 3'd4;
  localparam step_t STEP_ACC1  = 3'd5;
  localparam step_t STEP_ACC2  = 3'd6;
  localparam step_t STEP_ACC3  = 3'd7;

  typedef enum logic [2:0] {
    COEF_GAIN,
    COEF_FB1,
    COEF_FB2,
    COEF_FB3,
    COEF_FB4
  } coef_sel_t;

  typedef enum logic {
    OPB_X,
    OPB_Y
  } opb_sel_t;

  typedef enum logic [1:0] {
    TAP_T1,
    TAP_T4,
    TAP_T6
  } tap_sel_t;

  typedef enum logic [1:0] {
    JMP_NEXT,
    JMP_WAIT_IN,
    JMP_WAIT_OUT,
    JMP_GOTO
  } jmp_t;

  typedef struct packed {
    logic      mul_en;
    coef_sel_t coef_sel;
    opb_sel_t  opb_sel;
    logic      y_load;
    logic      d_wr;
    logic [1:0] d_idx;
    tap_sel_t  tap_sel;
    jmp_t      jmp;
    step_t     target;
  } ctrl_word_t;

  // Microprogram: one control word per step.
  function automatic ctrl_word_t ucode(input step_t s);
    ctrl_word_t w;
    w = '0;
    w.jmp = JMP_NEXT;
    unique case (s)
      STEP_IDLE: begin
        w.jmp = JMP_WAIT_IN;
      end
      STEP_MUL_X: begin
        w.mul_en   = 1'b1;
        w.coef_sel = COEF_GAIN;
        w.opb_sel  = OPB_X;
      end
      STEP_Y: begin
        w.y_load = 1'b1;
        w.jmp    = JMP_WAIT_OUT;
      end
      STEP_MUL_F: begin
        w.mul_en   = 1'b1;
        w.coef_sel = COEF_FB1;
        w.opb_sel  = OPB_Y;
      end
      STEP_ACC0: begin
        w.mul_en   = 1'b1;
        w.coef_sel = COEF_FB2;
        w.opb_sel  = OPB_Y;
        w.d_wr     = 1'b1;
        w.d_idx    = 2'd0;
        w.tap_sel  = TAP_T4;
      end
      STEP_ACC1: begin
        w.mul_en   = 1'b1;
        w.coef_sel = COEF_FB3;
        w.opb_sel  = OPB_Y;
        w.d_wr     = 1'b1;
        w.d_idx    = 2'd1;
        w.tap_sel  = TAP_T6;
      end
      STEP_ACC2: begin
        w.mul_en   = 1'b1;
        w.coef_sel = COEF_FB4;
        w.opb_sel  = OPB_Y;
        w.d_wr     = 1'b1;
        w.d_idx    = 2'd2;
        w.tap_sel  = TAP_T4;
      end
      STEP_ACC3: begin
        w.d_wr    = 1'b1;
        w.d_idx   = 2'd3;
        w.tap_sel = TAP_T1;
        w.jmp     = JMP_GOTO;
        w.target  = STEP_IDLE;
      end
      default: begin
        w.jmp    = JMP_GOTO;
        w.target = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

/* sv/four_pole_resonant_lowpass_unit.sv */
// Input beats are taken only in the idle step; the shared 32x24 multiplier then runs
// five products in series, gain first, sequenced by an 8-step microprogram. The output
// step registers the saturated sum and holds while the output is back-pressured.
// Reset (rst, synchronous, active high) clears the delay sums, the coefficient registers,
// the program step and the output valid; no clearing pass is needed.
`include "four_pole_resonant_lowpass_unit_macros.svh"

module four_pole_resonant_lowpass_unit (
  input  logic                                clk,
  input  logic                                rst,
  // Input stream. tdata: sample_in [23:0]
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [fprl_pkg::SAMPLE_W-1:0]       s_axis_tdata,
  // Output stream. tdata: sample_out [23:0]
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [fprl_pkg::SAMPLE_W-1:0]       m_axis_tdata,
  // Coefficient write port: 0 gain, 1..4 feedback one to four.
  input  logic                                cfg_we,
  input  logic [fprl_pkg::REG_IDX_W-1:0]      cfg_index,
  input  logic [fprl_pkg::COEF_W-1:0]         cfg_data
);

  localparam int SW = fprl_pkg::SAMPLE_W;
  localparam int CW = fprl_pkg::COEF_W;
  localparam int DW = fprl_pkg::DELAY_W;
  localparam int PW = fprl_pkg::PROD_W;
  localparam int FR = fprl_pkg::COEF_FRAC;
  localparam int T1W = fprl_pkg::T1_W;
  localparam int T4W = fprl_pkg::T4_W;
  localparam int T6W = fprl_pkg::T6_W;
  localparam int YW = fprl_pkg::YSUM_W;
  localparam int AW = fprl_pkg::ACC_W;

  // Saturate the output sum to the sample range.
  function automatic logic [SW-1:0] sat_sample(input logic [YW-1:0] v);
    logic [SW-1:0] r;
    if ((v[YW-1:SW-1] == '0) || (v[YW-1:SW-1] == '1)) begin
      r = v[SW-1:0];
    end else if (v[YW-1]) begin
      r = {1'b1, {(SW-1){1'b0}}};
    end else begin
      r = {1'b0, {(SW-1){1'b1}}};
    end
    return r;
  endfunction

  // Saturate an accumulated delay sum to the delay range.
  function automatic logic [DW-1:0] sat_delay(input logic [AW-1:0] v);
    logic [DW-1:0] r;
    if ((v[AW-1:DW-1] == '0) || (v[AW-1:DW-1] == '1)) begin
      r = v[DW-1:0];
    end else if (v[AW-1]) begin
      r = {1'b1, {(DW-1){1'b0}}};
    end else begin
      r = {1'b0, {(DW-1){1'b1}}};
    end
    return r;
  endfunction

  // Sequencer and control word.
  fprl_pkg::step_t      step;
  fprl_pkg::step_t      step_next;
  fprl_pkg::ctrl_word_t ctrl;

  logic in_acc;
  logic out_free;
  logic y_go;

  // Coefficients.
  logic [CW-1:0] gain;
  logic [CW-1:0] fb1;
  logic [CW-1:0] fb2;
  logic [CW-1:0] fb3;
  logic [CW-1:0] fb4;

  // Datapath.
  logic [SW-1:0]        x_r;
  logic [SW-1:0]        y_r;
  logic signed [CW-1:0] mul_a;
  logic signed [SW-1:0] mul_b;
  logic signed [PW-1:0] mul_res;
  logic [PW-1:0]        prod;
  logic [T1W-1:0]       prod_hi;
  logic [PW+2:0]        six_p;
  logic [T1W-1:0]       tap1;
  logic [T4W-1:0]       tap4;
  logic [T6W-1:0]       tap6;
  logic [T6W-1:0]       tap_mux;
  logic [DW-1:0]        d [fprl_pkg::NUM_DELAY];
  logic [DW-1:0]        d_in;
  logic [1:0]           d_rd_idx;
  logic [YW-1:0]        y_sum;
  logic [SW-1:0]        y_sat;
  logic [AW-1:0]        acc_sum;
  logic [DW-1:0]        acc_sat;

  // Next step: each step either falls through, waits on a handshake, or jumps.
  always_comb begin
    step_next = step;
    unique case (ctrl.jmp)
      fprl_pkg::JMP_NEXT:     step_next = step + fprl_pkg::step_t'(1);
      fprl_pkg::JMP_WAIT_IN:  step_next = in_acc ? step + fprl_pkg::step_t'(1) : step;
      fprl_pkg::JMP_WAIT_OUT: step_next = out_free ? step + fprl_pkg::step_t'(1) : step;
      fprl_pkg::JMP_GOTO:     step_next = ctrl.target;
      default:                step_next = fprl_pkg::STEP_IDLE;
    endcase
  end

  // Control decode from the program table. No input beat is taken while in reset.
  always_comb begin
    ctrl          = fprl_pkg::ucode(step);
    s_axis_tready = (ctrl.jmp == fprl_pkg::JMP_WAIT_IN) && !rst;
    in_acc        = s_axis_tvalid && s_axis_tready;
    out_free      = !m_axis_tvalid || m_axis_tready;
    y_go          = ctrl.y_load && out_free;
  end

  // Shared multiplier operands.
  always_comb begin
    unique case (ctrl.coef_sel)
      fprl_pkg::COEF_GAIN: mul_a = gain;
      fprl_pkg::COEF_FB1:  mul_a = fb1;
      fprl_pkg::COEF_FB2:  mul_a = fb2;
      fprl_pkg::COEF_FB3:  mul_a = fb3;
      fprl_pkg::COEF_FB4:  mul_a = fb4;
      default:             mul_a = '0;
    endcase
    mul_b = (ctrl.opb_sel == fprl_pkg::OPB_X) ? x_r : y_r;
  end

  assign mul_res = mul_a * mul_b;

  // Product scaled down to sample units; taking the top bits is a floor.
  assign prod_hi = prod[PW-1:FR];

  // 6*P = 4*P + 2*P, formed exactly before scaling.
  assign six_p = {prod[PW-1], prod, 2'b00} + {{2{prod[PW-1]}}, prod, 1'b0};

  // Output sum: gain tap plus the first delay sum.
  assign y_sum = {{(YW-T1W){prod_hi[T1W-1]}}, prod_hi} + {d[0][DW-1], d[0]};
  assign y_sat = sat_sample(y_sum);

  // Accumulate step: tap + feedback product + following delay sum (zero for the last).
  always_comb begin
    unique case (ctrl.tap_sel)
      fprl_pkg::TAP_T1: tap_mux = {{(T6W-T1W){tap1[T1W-1]}}, tap1};
      fprl_pkg::TAP_T4: tap_mux = {{(T6W-T4W){tap4[T4W-1]}}, tap4};
      fprl_pkg::TAP_T6: tap_mux = tap6;
      default:          tap_mux = '0;
    endcase
    d_rd_idx = ctrl.d_idx + 2'd1;
    d_in     = (ctrl.d_idx == 2'd3) ? '0 : d[d_rd_idx];
  end

  assign acc_sum = {{(AW-T6W){tap_mux[T6W-1]}}, tap_mux}
                 + {{(AW-T1W){prod_hi[T1W-1]}}, prod_hi}
                 + {{(AW-DW){d_in[DW-1]}}, d_in};
  assign acc_sat = sat_delay(acc_sum);

  // Control state, coefficients and delay sums.
  always_ff @(posedge clk) begin
    if (rst) begin
      step          <= fprl_pkg::STEP_IDLE;
      m_axis_tvalid <= 1'b0;
      gain          <= '0;
      fb1           <= '0;
      fb2           <= '0;
      fb3           <= '0;
      fb4           <= '0;
      for (int i = 0; i < fprl_pkg::NUM_DELAY; i++) begin
        d[i] <= '0;
      end
    end else begin
      step <= step_next;
      if (y_go) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          fprl_pkg::REG_GAIN: gain <= cfg_data;
          fprl_pkg::REG_FB1:  fb1  <= cfg_data;
          fprl_pkg::REG_FB2:  fb2  <= cfg_data;
          fprl_pkg::REG_FB3:  fb3  <= cfg_data;
          fprl_pkg::REG_FB4:  fb4  <= cfg_data;
          default: ;
        endcase
      end
      if (ctrl.d_wr) begin
        d[ctrl.d_idx] <= acc_sat;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      x_r <= s_axis_tdata;
    end
    if (ctrl.mul_en) begin
      prod <= mul_res;
    end
    if (y_go) begin
      y_r          <= y_sat;
      m_axis_tdata <= y_sat;
      tap1         <= prod_hi;
      tap4         <= prod[PW-1:FR-2];
      tap6         <= six_p[PW+2:FR];
    end
  end

  `FPRL_ASSERT_NEXT(a_accept_starts, in_acc, step == fprl_pkg::STEP_MUL_X, "program not started")
  `FPRL_ASSERT_SAME(a_out_from_y, $rose(m_axis_tvalid), $past(step) == fprl_pkg::STEP_Y, "stray beat")
  `FPRL_ASSERT_NEXT(a_hold_y, step == fprl_pkg::STEP_Y && !out_free, $stable(step), "output step left")
  `FPRL_ASSERT_NEXT(a_last_wraps, step == fprl_pkg::STEP_ACC3, step == fprl_pkg::STEP_IDLE, "no wrap")

endmodule
